/* rtl/core/v3n_pkg.sv */
// ----------------------------------------------------------------------------
// v3n_pkg: shared types and constants for the 3-D vector normalizer
// Widths, register map codes and the data carried between pipeline cells.
// ----------------------------------------------------------------------------
package v3n_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_OUT   = 30;
    localparam int SQ_WIDTH   = 2 * DATA_WIDTH;     // squared length
    localparam int LEN_WIDTH  = DATA_WIDTH;         // floor sqrt of SQ
    localparam int REM_WIDTH  = LEN_WIDTH + 2;      // sqrt partial remainder
    localparam int DVD_WIDTH  = DATA_WIDTH + FRAC_OUT;
    localparam int Q_WIDTH    = FRAC_OUT + 1;       // quotient <= 2^30
    localparam int EPS_WIDTH  = 16;
    localparam int ADDR_WIDTH = 3;
    localparam int SQRT_CELLS = LEN_WIDTH;
    localparam int DIV_CELLS  = Q_WIDTH;

    // register index codes
    localparam logic REG_EPSILON = 1'b0;

    // integer square root cell data
    typedef struct packed {
        logic                          valid;
        logic [SQ_WIDTH-1:0]           num;
        logic [REM_WIDTH-1:0]          rem;
        logic [LEN_WIDTH-1:0]          root;
        logic [2:0][DATA_WIDTH-1:0]    mag;
        logic [2:0]                    neg;
    } sqrt_t;

    // long division cell data, three lanes sharing one divisor
    typedef struct packed {
        logic                          valid;
        logic                          zero;
        logic [DVD_WIDTH-1:0]          dsr;
        logic [2:0][DVD_WIDTH-1:0]     rem;
        logic [2:0][Q_WIDTH-1:0]       quo;
        logic [2:0]                    neg;
    } div_t;

endpackage

/* rtl/core/vector3_normalize.sv */
// ----------------------------------------------------------------------------
// vector3_normalize: 3-D vector normalization, Q16.16 in, Q2.30 out
// Squared length, floor square root, epsilon test and per-component divide.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one vector (s_in_x, s_in_y, s_in_z) per transfer.
//   Result channel m_*: one transfer per vector with m_norm_x/y/z and
//   m_is_zero. Register epsilon at byte address 0 over the APB port.
// Pipeline: 68 register stages (input, square and sum stages, 32 square-root
//   cells, epsilon stage, 31 divider cells, output).
// Throughput: one vector per cycle while the output is not stalled; every cell
//   of the root and divider rows takes a new item each cycle unless the row holds.
// Stall: while m_valid is high and m_ready low the whole row holds; the
//   input register still takes one more transfer if it is empty.
// Reset: all valid bits clear, epsilon returns to 1. No clearing pass.
// Vectors shorter than epsilon (or of zero length) give the zero vector with
//   m_is_zero set.
// ----------------------------------------------------------------------------
module vector3_normalize (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [v3n_pkg::DATA_WIDTH-1:0] s_in_x,
    input  logic signed [v3n_pkg::DATA_WIDTH-1:0] s_in_y,
    input  logic signed [v3n_pkg::DATA_WIDTH-1:0] s_in_z,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [31:0]                m_norm_x,
    output logic signed [31:0]                m_norm_y,
    output logic signed [31:0]                m_norm_z,
    output logic                              m_is_zero,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [v3n_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int DW = v3n_pkg::DATA_WIDTH;

    logic                          adv;
    logic [v3n_pkg::EPS_WIDTH-1:0] eps_reg;
    logic [v3n_pkg::EPS_WIDTH-1:0] thr;

    logic                          v0_reg, v1_reg;
    logic [2:0][DW-1:0]            mag0_reg, mag1_reg;
    logic [2:0]                    neg0_reg, neg1_reg;
    logic [2:0][DW-1:0]            in_vec;
    logic [2:0][v3n_pkg::SQ_WIDTH-1:0] sqr1_reg;

    v3n_pkg::sqrt_t sum_reg;
    v3n_pkg::sqrt_t sq_chain [0:v3n_pkg::SQRT_CELLS];
    v3n_pkg::div_t  dv_chain [0:v3n_pkg::DIV_CELLS];
    v3n_pkg::div_t  dv_next;
    v3n_pkg::div_t  dv_reg;

    logic                          out_valid_reg;
    logic [2:0][31:0]              out_norm_reg;
    logic                          out_zero_reg;

    // config port
    assign pready = 1'b1;
    assign prdata = {{(32 - v3n_pkg::EPS_WIDTH){1'b0}}, eps_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= v3n_pkg::EPS_WIDTH'(1);
        end else if (psel && penable && pwrite && paddr[2] == v3n_pkg::REG_EPSILON) begin
            eps_reg <= pwdata[v3n_pkg::EPS_WIDTH-1:0];
        end
    end

    // row advances unless the output holds an unaccepted result
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv || !v0_reg;
    assign in_vec  = {s_in_z, s_in_y, s_in_x};

    // input stage: magnitude and sign
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (s_ready) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            for (int i = 0; i < 3; i++) begin
                neg0_reg[i] <= in_vec[i][DW-1];
                mag0_reg[i] <= in_vec[i][DW-1] ? (DW'(0) - in_vec[i]) : in_vec[i];
            end
        end
    end

    // square stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            sum_reg.valid <= 1'b0;
        end else if (adv) begin
            v1_reg        <= v0_reg;
            sum_reg.valid <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                sqr1_reg[i] <= v3n_pkg::SQ_WIDTH'(mag0_reg[i]) *
                               v3n_pkg::SQ_WIDTH'(mag0_reg[i]);
            end
            mag1_reg <= mag0_reg;
            neg1_reg <= neg0_reg;
        end
    end

    // sum stage feeds the root row
    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg.num  <= sqr1_reg[0] + sqr1_reg[1] + sqr1_reg[2];
            sum_reg.rem  <= '0;
            sum_reg.root <= '0;
            sum_reg.mag  <= mag1_reg;
            sum_reg.neg  <= neg1_reg;
        end
    end
    assign sq_chain[0] = sum_reg;

    // square root row
    for (genvar g = 0; g < v3n_pkg::SQRT_CELLS; g++) begin : g_sqrt
        v3n_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .d_in    (sq_chain[g]),
            .d_out   (sq_chain[g+1])
        );
    end

    // epsilon test and divider setup
    assign thr = (eps_reg == '0) ? v3n_pkg::EPS_WIDTH'(1) : eps_reg;

    always_comb begin
        dv_next.valid = sq_chain[v3n_pkg::SQRT_CELLS].valid;
        dv_next.zero  = sq_chain[v3n_pkg::SQRT_CELLS].root <
                        v3n_pkg::LEN_WIDTH'(thr);
        dv_next.dsr   = {sq_chain[v3n_pkg::SQRT_CELLS].root,
                         {v3n_pkg::FRAC_OUT{1'b0}}};
        for (int i = 0; i < 3; i++) begin
            dv_next.rem[i] = {sq_chain[v3n_pkg::SQRT_CELLS].mag[i],
                              {v3n_pkg::FRAC_OUT{1'b0}}};
        end
        dv_next.quo = '0;
        dv_next.neg = sq_chain[v3n_pkg::SQRT_CELLS].neg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg.valid <= 1'b0;
        end else if (adv) begin
            dv_reg.valid <= dv_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg.zero <= dv_next.zero;
            dv_reg.dsr  <= dv_next.dsr;
            dv_reg.rem  <= dv_next.rem;
            dv_reg.quo  <= dv_next.quo;
            dv_reg.neg  <= dv_next.neg;
        end
    end
    assign dv_chain[0] = dv_reg;

    // divider row
    for (genvar g = 0; g < v3n_pkg::DIV_CELLS; g++) begin : g_div
        v3n_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .d_in    (dv_chain[g]),
            .d_out   (dv_chain[g+1])
        );
    end

    // output register: sign and zero vector
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_chain[v3n_pkg::DIV_CELLS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_zero_reg <= dv_chain[v3n_pkg::DIV_CELLS].zero;
            for (int i = 0; i < 3; i++) begin
                if (dv_chain[v3n_pkg::DIV_CELLS].zero) begin
                    out_norm_reg[i] <= '0;
                end else if (dv_chain[v3n_pkg::DIV_CELLS].neg[i]) begin
                    out_norm_reg[i] <= 32'(0) - 32'(dv_chain[v3n_pkg::DIV_CELLS].quo[i]);
                end else begin
                    out_norm_reg[i] <= 32'(dv_chain[v3n_pkg::DIV_CELLS].quo[i]);
                end
            end
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_norm_x  = out_norm_reg[0];
    assign m_norm_y  = out_norm_reg[1];
    assign m_norm_z  = out_norm_reg[2];
    assign m_is_zero = out_zero_reg;

`ifndef SYNTH
    // zero flag means the zero vector
    a_zero_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_zero) |-> (m_norm_x == 0 && m_norm_y == 0 && m_norm_z == 0))
        else $error("zero flag with nonzero components");

    // unit components stay within +-1.0 in Q2.30
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_norm_x <= 32'sh4000_0000 && m_norm_x >= -32'sh4000_0000 &&
                     m_norm_y <= 32'sh4000_0000 && m_norm_y >= -32'sh4000_0000 &&
                     m_norm_z <= 32'sh4000_0000 && m_norm_z >= -32'sh4000_0000))
        else $error("normalized component out of range");

    // a stalled output freezes the row: sum and epsilon stage valid bits hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(dv_reg.valid) && $stable(sum_reg.valid))
        else $error("pipeline moved during stall");
`endif

endmodule

/* rtl/core/v3n_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// v3n_sqrt_cell: one digit step of the integer square root
// Brings in two radicand bits and decides one root bit per cell.
// ----------------------------------------------------------------------------
module v3n_sqrt_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  v3n_pkg::sqrt_t d_in,
    output v3n_pkg::sqrt_t d_out
);

    logic [v3n_pkg::REM_WIDTH-1:0] rem_sh;
    logic [v3n_pkg::REM_WIDTH-1:0] trial;
    logic                          ge;
    v3n_pkg::sqrt_t                d_next;
    v3n_pkg::sqrt_t                d_reg;

    // trial subtract of (4*root + 1)
    always_comb begin
        rem_sh = {d_in.rem[v3n_pkg::REM_WIDTH-3:0],
                  d_in.num[v3n_pkg::SQ_WIDTH-1 -: 2]};
        trial  = {d_in.root, 2'b01};
        ge     = (rem_sh >= trial);
        d_next = d_in;
        d_next.num  = {d_in.num[v3n_pkg::SQ_WIDTH-3:0], 2'b00};
        d_next.rem  = ge ? (rem_sh - trial) : rem_sh;
        d_next.root = {d_in.root[v3n_pkg::LEN_WIDTH-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.valid <= 1'b0;
        end else if (en) begin
            d_reg.valid <= d_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg.num  <= d_next.num;
            d_reg.rem  <= d_next.rem;
            d_reg.root <= d_next.root;
            d_reg.mag  <= d_next.mag;
            d_reg.neg  <= d_next.neg;
        end
    end

    assign d_out = d_reg;

endmodule

/* rtl/core/v3n_div_cell.sv */
// ----------------------------------------------------------------------------
// v3n_div_cell: one quotient bit of the restoring divide, three lanes
// Compares each remainder with the shifted length and halves the divisor.
// ----------------------------------------------------------------------------
module v3n_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  v3n_pkg::div_t d_in,
    output v3n_pkg::div_t d_out
);

    logic [2:0]    ge;
    v3n_pkg::div_t d_next;
    v3n_pkg::div_t d_reg;

    // per-lane compare and subtract
    always_comb begin
        d_next = d_in;
        for (int i = 0; i < 3; i++) begin
            ge[i] = (d_in.rem[i] >= d_in.dsr);
            d_next.rem[i] = ge[i] ? (d_in.rem[i] - d_in.dsr) : d_in.rem[i];
            d_next.quo[i] = {d_in.quo[i][v3n_pkg::Q_WIDTH-2:0], ge[i]};
        end
        d_next.dsr = {1'b0, d_in.dsr[v3n_pkg::DVD_WIDTH-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.valid <= 1'b0;
        end else if (en) begin
            d_reg.valid <= d_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg.zero <= d_next.zero;
            d_reg.dsr  <= d_next.dsr;
            d_reg.rem  <= d_next.rem;
            d_reg.quo  <= d_next.quo;
            d_reg.neg  <= d_next.neg;
        end
    end

    assign d_out = d_reg;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for vector3_normalize
// Drives random and corner-case vectors through the streaming port, predicts
// each unit vector from the squared length, floor root and epsilon test, and
// compares every result transfer in order. Epsilon is changed between phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int LATENCY   = 69;
    localparam int WDOG_MAX  = 20000;
    localparam logic [v3n_pkg::ADDR_WIDTH-1:0] EPS_ADDR =
        v3n_pkg::ADDR_WIDTH'(4 * v3n_pkg::REG_EPSILON);

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic               zero;
    } unit_vec_t;

    // scoreboard: predicts unit vectors and checks results in order
    class norm_scoreboard;
        unit_vec_t   pending[$];
        logic [15:0] eps;
        int          errors;

        function new();
            eps    = 16'd1;
            errors = 0;
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] trial;
            root = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v) root = trial;
            end
            return root;
        endfunction

        function void note_vector(logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z);
            logic signed [63:0] comp[3];
            logic [63:0] mg[3];
            logic [63:0] sq, len, thr, q;
            logic [31:0] res[3];
            unit_vec_t   e;
            comp[0] = x; comp[1] = y; comp[2] = z;
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                mg[i] = comp[i] < 0 ? 64'(-comp[i]) : 64'(comp[i]);
                sq += mg[i] * mg[i];
            end
            len = floor_sqrt(sq);
            thr = (eps == 0) ? 64'd1 : 64'(eps);
            if (len < thr) begin
                e = '{nx: 0, ny: 0, nz: 0, zero: 1'b1};
            end else begin
                for (int i = 0; i < 3; i++) begin
                    q = (mg[i] << v3n_pkg::FRAC_OUT) / len;
                    res[i] = comp[i] < 0 ? 32'(-q) : 32'(q);
                end
                e = '{nx: res[0], ny: res[1], nz: res[2], zero: 1'b0};
            end
            pending.push_back(e);
        endfunction

        function void check_unit(unit_vec_t got);
            unit_vec_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp x=%h y=%h z=%h zero=%b got x=%h y=%h z=%h zero=%b",
                             want.nx, want.ny, want.nz, want.zero,
                             got.nx, got.ny, got.nz, got.zero);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready;
    logic signed [31:0] s_in_x = '0, s_in_y = '0, s_in_z = '0;
    logic m_valid, m_ready = 1'b0;
    logic signed [31:0] m_norm_x, m_norm_y, m_norm_z;
    logic m_is_zero;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [v3n_pkg::ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;

    norm_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    vector3_normalize dut (.*);

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // result side: random stall, check each transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_unit('{nx: m_norm_x, ny: m_norm_y, nz: m_norm_z, zero: m_is_zero});
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_epsilon(logic [15:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= EPS_ADDR;
        pwdata  <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.eps = value;
    endtask

    // one input transfer, with a random gap ahead of it
    task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_x  <= x;
        s_in_y  <= y;
        s_in_z  <= z;
        do @(posedge aclk); while (!s_ready);
        sb.note_vector(x, y, z);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(65535)) - 32768);
            2:       return 32'($signed($urandom_range(4194303)) - 2097152);
            3:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            4:       return 32'($signed($urandom_range(6)) - 3);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_vector(rand_comp(), rand_comp(), rand_comp());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners at reset epsilon
        send_vector(0, 0, 0);
        send_vector(1, 0, 0);
        send_vector(32'h0001_0000, 0, 0);
        send_vector(0, 32'hffff_0000, 0);
        send_vector(0, 0, 32'h8000_0000);
        send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vector(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
        send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_vector(32'hfffe_0000, 32'h0003_0000, 32'hfffa_0000);
        send_vector(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_f0f0);
        drain();

        // epsilon of zero: zero length still flagged
        write_epsilon(16'd0);
        send_vector(0, 0, 0);
        send_vector(1, 0, 0);
        send_vector(32'hffff_ffff, 0, 0);
        random_phase(280);
        drain();

        // largest epsilon, sender idles
        write_epsilon(16'hffff);
        send_idle_pct = 54;
        send_vector(32'h0000_ffff, 0, 0);
        send_vector(32'h0001_0000, 0, 0);
        send_vector(0, 32'hffff_0001, 0);
        random_phase(320);
        drain();

        // receiver stalls
        write_epsilon(16'h0100);
        send_idle_pct = 0;
        recv_stall_pct = 54;
        random_phase(320);
        drain();

        // both sides idle
        write_epsilon(16'($urandom));
        send_idle_pct = 36;
        recv_stall_pct = 36;
        random_phase(300);
        drain();

        // back to full rate
        write_epsilon(16'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(300);
        drain();

        if (sb.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
